// ----- rtl/qpoa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qpoa_pkg;

    localparam int IN_W  = 288;
    localparam int OUT_W = 32;

    // clip pass order: left, right, bottom, top
    localparam logic [1:0] PASS_LEFT   = 2'd0;
    localparam logic [1:0] PASS_RIGHT  = 2'd1;
    localparam logic [1:0] PASS_BOTTOM = 2'd2;
    localparam logic [1:0] PASS_TOP    = 2'd3;

    typedef struct packed {
        logic load_in;
        logic load_wr;
        logic pass_init;
        logic rd_last;
        logic take_prev;
        logic take_cur;
        logic md_start;
        logic wr_cross;
        logic wr_cur;
        logic advance;
        logic pass_end;
        logic area_init;
        logic take_first;
        logic close_start;
        logic mul1;
        logic mul2;
        logic mul3;
        logic fin1;
        logic res_wr;
        logic res_zero;
    } cmd_t;

    typedef struct packed {
        logic load_last;
        logic last_vert;
        logic need_cross;
        logic keep_cur;
        logic few;
        logic last_pass;
        logic md_done;
        logic i_zero;
        logic closing;
        logic out_full;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/qpoa_muldiv.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial a*b/d, rounded to nearest. Requires a <= d, so the quotient fits MW bits.
module qpoa_muldiv #(
    parameter int MW = 35
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [MW-1:0] a,
    input  wire logic [MW-1:0] b,
    input  wire logic [MW-1:0] d,
    output logic               done,
    output logic [MW-1:0]      q
);

    localparam int CNTW = $clog2(MW + 1);
    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;
    localparam logic [1:0] MD_RND  = 2'd3;

    logic [1:0]      phase_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [2*MW-1:0] prod_reg;
    logic [2*MW-1:0] mcand_reg;
    logic [MW-1:0]   mplier_reg;
    logic [MW-1:0]   d_reg;
    logic [MW-1:0]   q_reg;

    logic [MW:0]     trial;
    logic            ge;
    logic [MW:0]     diff;
    logic [MW:0]     twice_rem;

    assign trial     = {prod_reg[2*MW-1:MW], prod_reg[MW-1]};
    assign ge        = trial >= {1'b0, d_reg};
    assign diff      = trial - {1'b0, d_reg};
    assign twice_rem = {prod_reg[2*MW-1:MW], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == MD_RND);
            case (phase_reg)
                MD_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= MD_MUL;
                        cnt_reg   <= '0;
                    end
                end
                MD_MUL:
                begin
                    if (cnt_reg == CNTW'(MW - 1))
                    begin
                        phase_reg <= MD_DIV;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                MD_DIV:
                begin
                    if (cnt_reg == CNTW'(MW - 1))
                    begin
                        phase_reg <= MD_RND;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                MD_RND:
                begin
                    phase_reg <= MD_IDLE;
                end
                default:
                begin
                    phase_reg <= MD_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    prod_reg   <= '0;
                    mcand_reg  <= {{MW{1'b0}}, a};
                    mplier_reg <= b;
                    d_reg      <= d;
                end
            end
            MD_MUL:
            begin
                if (mplier_reg[0])
                begin
                    prod_reg <= prod_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[2*MW-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[MW-1:1]};
            end
            MD_DIV:
            begin
                // high half is the running remainder, low half shifts in
                prod_reg <= {(ge ? diff[MW-1:0] : trial[MW-1:0]),
                             prod_reg[MW-2:0], 1'b0};
                q_reg    <= {q_reg[MW-2:0], ge};
            end
            MD_RND:
            begin
                if (twice_rem >= {1'b0, d_reg})
                begin
                    q_reg <= q_reg + 1'b1;
                end
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

`default_nettype wire

// ----- rtl/qpoa_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qpoa_datapath
    import qpoa_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_VERTICES = 12
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             cmd,
    output sts_t                  sts,
    input  wire logic [IN_W-1:0]  in_data,
    input  wire logic             out_taken,
    output logic                  out_valid,
    output logic [30:0]           out_area
);

    localparam int CW  = ((32 > FRAC_BITS + 17) ? 32 : FRAC_BITS + 17) + 1;
    localparam int MW  = CW + 1;
    localparam int UW  = FRAC_BITS + 1;
    localparam int SW  = 2 * UW + 2 + $clog2(MAX_VERTICES);
    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int SH  = 2 * FRAC_BITS + 1 - 30;
    localparam int SHR = (SH > 0) ? SH : 0;
    localparam int SHL = (SH > 0) ? 0 : -SH;
    localparam int RW  = SW + SHL + 1;

    localparam logic signed [CW-1:0] HALF    = CW'(64'd1 << (FRAC_BITS - 1));
    localparam logic [RW-1:0]        RND_ADD = (RW'(1) << SHR) >> 1;
    localparam logic [RW-1:0]        SAT     = RW'(1) << 30;

    // input latch
    logic [31:0]       vx_reg [4];
    logic [31:0]       vy_reg [4];
    logic [15:0]       px_reg;
    logic [15:0]       py_reg;

    // vertex banks, {y, x}
    logic [2*CW-1:0]   bank0 [MAX_VERTICES];
    logic [2*CW-1:0]   bank1 [MAX_VERTICES];
    logic [2*CW-1:0]   rd0_reg;
    logic [2*CW-1:0]   rd1_reg;

    logic              src_sel_reg;
    logic [1:0]        pass_reg;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     i_reg;
    logic [NW-1:0]     w_reg;

    logic signed [CW-1:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic signed [CW-1:0] first_x_reg, first_y_reg;
    logic              pin_reg;
    logic              cin_reg;
    logic              closing_reg;

    logic [2*UW-1:0]   prod_reg;
    logic signed [SW-1:0] acc_reg;
    logic [SW-1:0]     mag_reg;
    logic [30:0]       res_reg;
    logic              out_valid_reg;

    logic [NW-1:0]     rd_idx;
    logic [AW-1:0]     rd_addr;
    logic [2*CW-1:0]   rd_pt;
    logic signed [CW-1:0] rd_x, rd_y, rd_a;
    logic              axis_y;
    logic              upper;
    logic              rd_keep;
    logic signed [CW-1:0] bound;
    logic signed [CW-1:0] pa, po, qa, qo;
    logic signed [CW:0] da, dq, dd;
    logic [MW-1:0]     mag_a, mag_b, mag_d;
    logic              md_done;
    logic [MW-1:0]     md_q;
    logic signed [CW+1:0] cross_w;
    logic signed [CW-1:0] cross_o;
    logic [2*CW-1:0]   cross_pt;
    logic [1:0]        ld_sel;
    logic signed [CW-1:0] ld_x, ld_y;
    logic              wr_en;
    logic              wr_bank;
    logic [AW-1:0]     wr_addr;
    logic [2*CW-1:0]   wr_data;
    logic signed [CW-1:0] sp_x, sp_y, sc_x, sc_y;
    logic [UW-1:0]     up_x, up_y, uc_x, uc_y;
    logic [RW-1:0]     rounded;
    logic [RW-1:0]     scaled;
    logic [30:0]       res_next;

    function automatic logic [MW-1:0] mag(input logic signed [CW:0] v);
        mag = v[CW] ? MW'(-v) : MW'(v);
    endfunction

    // read port: both banks, registered
    assign rd_idx  = cmd.rd_last ? (n_reg - 1'b1) : i_reg;
    assign rd_addr = rd_idx[AW-1:0];
    assign rd_pt   = src_sel_reg ? rd1_reg : rd0_reg;
    assign rd_x    = rd_pt[CW-1:0];
    assign rd_y    = rd_pt[2*CW-1:CW];

    assign axis_y  = pass_reg[1];
    assign upper   = pass_reg[0];
    assign bound   = upper ? HALF : -HALF;
    assign rd_a    = axis_y ? rd_y : rd_x;
    assign rd_keep = upper ? (rd_a <= HALF) : (rd_a >= -HALF);

    // crossing operands
    assign pa    = axis_y ? prev_y_reg : prev_x_reg;
    assign po    = axis_y ? prev_x_reg : prev_y_reg;
    assign qa    = axis_y ? cur_y_reg : cur_x_reg;
    assign qo    = axis_y ? cur_x_reg : cur_y_reg;
    assign da    = {bound[CW-1], bound} - {pa[CW-1], pa};
    assign dq    = {qo[CW-1], qo} - {po[CW-1], po};
    assign dd    = {qa[CW-1], qa} - {pa[CW-1], pa};
    assign mag_a = mag(da);
    assign mag_b = mag(dq);
    assign mag_d = mag(dd);

    qpoa_muldiv #(
        .MW (MW)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.md_start),
        .a     (mag_a),
        .b     (mag_b),
        .d     (mag_d),
        .done  (md_done),
        .q     (md_q)
    );

    assign cross_w  = dq[CW] ? ({{2{po[CW-1]}}, po} - {1'b0, md_q})
                             : ({{2{po[CW-1]}}, po} + {1'b0, md_q});
    assign cross_o  = cross_w[CW-1:0];
    assign cross_pt = axis_y ? {bound, cross_o} : {cross_o, bound};

    // load: coordinates relative to the pixel centre
    assign ld_sel = i_reg[1:0];
    assign ld_x   = CW'($signed(vx_reg[ld_sel])) - $signed({{(CW - 16 - FRAC_BITS){1'b0}},
                    px_reg, {FRAC_BITS{1'b0}}});
    assign ld_y   = CW'($signed(vy_reg[ld_sel])) - $signed({{(CW - 16 - FRAC_BITS){1'b0}},
                    py_reg, {FRAC_BITS{1'b0}}});

    assign wr_en   = cmd.load_wr | cmd.wr_cross | cmd.wr_cur;
    assign wr_bank = cmd.load_wr ? 1'b0 : ~src_sel_reg;
    assign wr_addr = cmd.load_wr ? i_reg[AW-1:0] : w_reg[AW-1:0];
    assign wr_data = cmd.load_wr  ? {ld_y, ld_x}
                   : cmd.wr_cross ? cross_pt
                   : {cur_y_reg, cur_x_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_bank)
        begin
            bank0[wr_addr] <= wr_data;
        end
        rd0_reg <= bank0[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_bank)
        begin
            bank1[wr_addr] <= wr_data;
        end
        rd1_reg <= bank1[rd_addr];
    end

    // shoelace coordinates shifted by +H, all in [0, 2H] after clipping
    assign sp_x = prev_x_reg + HALF;
    assign sp_y = prev_y_reg + HALF;
    assign sc_x = cur_x_reg + HALF;
    assign sc_y = cur_y_reg + HALF;
    assign up_x = sp_x[UW-1:0];
    assign up_y = sp_y[UW-1:0];
    assign uc_x = sc_x[UW-1:0];
    assign uc_y = sc_y[UW-1:0];

    assign rounded  = RW'(mag_reg) + RND_ADD;
    assign scaled   = (rounded >> SHR) << SHL;
    assign res_next = (scaled > SAT) ? SAT[30:0] : scaled[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_sel_reg   <= 1'b0;
            pass_reg      <= PASS_LEFT;
            n_reg         <= '0;
            i_reg         <= '0;
            w_reg         <= '0;
            closing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                src_sel_reg <= 1'b0;
                pass_reg    <= PASS_LEFT;
                n_reg       <= NW'(4);
                i_reg       <= '0;
            end
            if (cmd.load_wr || cmd.advance)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.pass_init || cmd.area_init)
            begin
                i_reg <= '0;
            end
            if (cmd.pass_init)
            begin
                w_reg <= '0;
            end
            if (cmd.take_first)
            begin
                i_reg <= NW'(1);
            end
            if (cmd.wr_cross || cmd.wr_cur)
            begin
                w_reg <= w_reg + 1'b1;
            end
            if (cmd.pass_end)
            begin
                n_reg       <= w_reg;
                src_sel_reg <= ~src_sel_reg;
                pass_reg    <= pass_reg + 1'b1;
            end
            if (cmd.area_init)
            begin
                closing_reg <= 1'b0;
            end
            if (cmd.close_start)
            begin
                closing_reg <= 1'b1;
            end
            if (cmd.res_wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            for (int k = 0; k < 4; k++)
            begin
                vx_reg[k] <= in_data[64*k +: 32];
                vy_reg[k] <= in_data[64*k+32 +: 32];
            end
            px_reg <= in_data[256 +: 16];
            py_reg <= in_data[272 +: 16];
        end
        if (cmd.take_prev)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
            pin_reg    <= rd_keep;
        end
        if (cmd.take_cur)
        begin
            cur_x_reg <= rd_x;
            cur_y_reg <= rd_y;
            cin_reg   <= rd_keep;
        end
        if (cmd.advance)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
            pin_reg    <= cin_reg;
        end
        if (cmd.take_first)
        begin
            prev_x_reg  <= rd_x;
            prev_y_reg  <= rd_y;
            first_x_reg <= rd_x;
            first_y_reg <= rd_y;
        end
        if (cmd.close_start)
        begin
            cur_x_reg <= first_x_reg;
            cur_y_reg <= first_y_reg;
        end
        if (cmd.area_init)
        begin
            acc_reg <= '0;
        end
        if (cmd.mul1)
        begin
            prod_reg <= up_x * uc_y;
        end
        if (cmd.mul2)
        begin
            acc_reg  <= acc_reg + $signed(SW'(prod_reg));
            prod_reg <= uc_x * up_y;
        end
        if (cmd.mul3)
        begin
            acc_reg <= acc_reg - $signed(SW'(prod_reg));
        end
        if (cmd.fin1)
        begin
            mag_reg <= acc_reg[SW-1] ? SW'(-acc_reg) : SW'(acc_reg);
        end
        if (cmd.res_wr)
        begin
            res_reg <= cmd.res_zero ? '0 : res_next;
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.load_last  = (i_reg == NW'(3));
        sts.last_vert  = ({1'b0, i_reg} + 1'b1) == {1'b0, n_reg};
        sts.need_cross = (cin_reg != pin_reg) && (w_reg < NW'(MAX_VERTICES));
        sts.keep_cur   = cin_reg && (w_reg < NW'(MAX_VERTICES));
        sts.few        = w_reg < NW'(3);
        sts.last_pass  = (pass_reg == PASS_TOP);
        sts.md_done    = md_done;
        sts.i_zero     = (i_reg == '0);
        sts.closing    = closing_reg;
        sts.out_full   = out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_area  = res_reg;

endmodule

`default_nettype wire

// ----- rtl/qpoa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qpoa_ctrl
    import qpoa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LOAD   = 5'd1;
    localparam logic [4:0] S_PINIT  = 5'd2;
    localparam logic [4:0] S_PPREV  = 5'd3;
    localparam logic [4:0] S_PRD    = 5'd4;
    localparam logic [4:0] S_PCUR   = 5'd5;
    localparam logic [4:0] S_PDEC   = 5'd6;
    localparam logic [4:0] S_PWAIT  = 5'd7;
    localparam logic [4:0] S_PXW    = 5'd8;
    localparam logic [4:0] S_PKEEP  = 5'd9;
    localparam logic [4:0] S_PEND   = 5'd10;
    localparam logic [4:0] S_ZERO   = 5'd11;
    localparam logic [4:0] S_AINIT  = 5'd12;
    localparam logic [4:0] S_ARD    = 5'd13;
    localparam logic [4:0] S_AGET   = 5'd14;
    localparam logic [4:0] S_AM1    = 5'd15;
    localparam logic [4:0] S_AM2    = 5'd16;
    localparam logic [4:0] S_AM3    = 5'd17;
    localparam logic [4:0] S_ACLOSE = 5'd18;
    localparam logic [4:0] S_AF1    = 5'd19;
    localparam logic [4:0] S_AF2    = 5'd20;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_wr = 1'b1;
                if (sts.load_last)
                begin
                    state_next = S_PINIT;
                end
            end
            S_PINIT:
            begin
                cmd.pass_init = 1'b1;
                cmd.rd_last   = 1'b1;
                state_next    = S_PPREV;
            end
            S_PPREV:
            begin
                cmd.take_prev = 1'b1;
                state_next    = S_PCUR;
            end
            S_PRD:
            begin
                state_next = S_PCUR;
            end
            S_PCUR:
            begin
                cmd.take_cur = 1'b1;
                state_next   = S_PDEC;
            end
            S_PDEC:
            begin
                if (sts.need_cross)
                begin
                    cmd.md_start = 1'b1;
                    state_next   = S_PWAIT;
                end
                else
                begin
                    state_next = S_PKEEP;
                end
            end
            S_PWAIT:
            begin
                if (sts.md_done)
                begin
                    state_next = S_PXW;
                end
            end
            S_PXW:
            begin
                cmd.wr_cross = 1'b1;
                state_next   = S_PKEEP;
            end
            S_PKEEP:
            begin
                cmd.wr_cur  = sts.keep_cur;
                cmd.advance = 1'b1;
                state_next  = sts.last_vert ? S_PEND : S_PRD;
            end
            S_PEND:
            begin
                cmd.pass_end = 1'b1;
                if (sts.few)
                begin
                    state_next = S_ZERO;
                end
                else if (sts.last_pass)
                begin
                    state_next = S_AINIT;
                end
                else
                begin
                    state_next = S_PINIT;
                end
            end
            S_ZERO:
            begin
                if (!sts.out_full)
                begin
                    cmd.res_wr   = 1'b1;
                    cmd.res_zero = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_AINIT:
            begin
                cmd.area_init = 1'b1;
                state_next    = S_ARD;
            end
            S_ARD:
            begin
                state_next = S_AGET;
            end
            S_AGET:
            begin
                if (sts.i_zero)
                begin
                    cmd.take_first = 1'b1;
                    state_next     = S_ARD;
                end
                else
                begin
                    cmd.take_cur = 1'b1;
                    state_next   = S_AM1;
                end
            end
            S_AM1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_AM2;
            end
            S_AM2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_AM3;
            end
            S_AM3:
            begin
                cmd.mul3    = 1'b1;
                cmd.advance = 1'b1;
                if (sts.closing)
                begin
                    state_next = S_AF1;
                end
                else if (sts.last_vert)
                begin
                    state_next = S_ACLOSE;
                end
                else
                begin
                    state_next = S_ARD;
                end
            end
            S_ACLOSE:
            begin
                cmd.close_start = 1'b1;
                state_next      = S_AM1;
            end
            S_AF1:
            begin
                cmd.fin1   = 1'b1;
                state_next = S_AF2;
            end
            S_AF2:
            begin
                if (!sts.out_full)
                begin
                    cmd.res_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/quad_pixel_overlap_area.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Bits  Contents
// s_axis    in   288   quad vertices and pixel centre, one request per quad
// m_axis    out  32    overlap area, 2^30 = 1.0
//
// Steps: load, then one clip pass per pixel edge, with a crossing point per edge
// that crosses it, then the shoelace area; coordinates are 34 bits wide at
// FRAC_BITS = 16. Crossings dominate: they run through one bit-serial
// multiply/divide unit, one bit per cycle.
// Reset: async, active low; clears the sequencer and the output valid.
// Stalls: one request in flight; the next request is taken while a finished
// result still waits in the output register.
module quad_pixel_overlap_area
    import qpoa_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_VERTICES = 12
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
    // vertex3_x, vertex3_y, pixel_x, pixel_y
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // overlap_area[30:0], bit 31 zero
    output logic [OUT_W-1:0]      m_axis_tdata
);

    cmd_t        cmd;
    sts_t        sts;
    logic [30:0] area;
    logic        out_taken;

    assign out_taken = m_axis_tvalid & m_axis_tready;

    qpoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    qpoa_datapath #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .out_taken (out_taken),
        .out_valid (m_axis_tvalid),
        .out_area  (area)
    );

    assign m_axis_tdata = {1'b0, area};

`ifndef ASSERT_OFF
    // a new result never lands on one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_wr |-> !m_axis_tvalid)
        else $error("result written over pending result");

    // one request in flight
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

    // a crossing point is stored only right after the divider finishes
    a_cross_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_cross |-> $past(sts.md_done))
        else $error("crossing written without divider result");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/quad_pixel_overlap_area_tb.sv -----
`timescale 1ns / 1ps

// Area of a clipped quad is predicted in the bench and compared with each
// m_axis response; inputs use random idling on both sides.
module quad_pixel_overlap_area_tb;
    import qpoa_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int MAXV      = 12;
    localparam int WDOG_LIM  = 20000;

    typedef struct {
        longint c[2];
    } pt_t;

    typedef pt_t poly_t[MAXV];

    logic            clk;
    logic            rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    logic [IN_W-1:0] pending_q[$];
    logic [30:0]     area_q[$];
    int              err_cnt;
    bit              gen_done;
    bit              calm;
    int              idle_s;
    int              idle_m;
    int              wdog;

    quad_pixel_overlap_area #(.FRAC_BITS(FRAC_BITS), .MAX_VERTICES(MAXV)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // vertex0_x .. vertex3_y (32 each), pixel_x, pixel_y (16 each)
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // overlap_area[30:0], bit 31 zero
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // crossing of edge p->q with the line c[axis] == bound
    function automatic pt_t cross_pt(pt_t p, pt_t q, int axis, longint bound);
        pt_t r;
        int oth;
        longint dq;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] rem;
        oth = 1 - axis;
        dq = q.c[oth] - p.c[oth];
        num = 128'(mag(bound - p.c[axis])) * 128'(mag(dq));
        den = 128'(mag(q.c[axis] - p.c[axis]));
        quo = num / den;
        rem = num % den;
        // nearest, ties away from p
        if (rem >= den - rem)
            quo = quo + 1;
        r.c[axis] = bound;
        r.c[oth] = dq < 0 ? p.c[oth] - longint'(quo[63:0]) : p.c[oth] + longint'(quo[63:0]);
        return r;
    endfunction

    function automatic int clip_edge(poly_t src, int n, output poly_t dst, input int axis,
                                     input bit upper, input longint bound);
        int w;
        bit ci;
        bit pi;
        pt_t prv;
        w = 0;
        for (int i = 0; i < n; i++)
        begin
            prv = src[i == 0 ? n - 1 : i - 1];
            ci = upper ? src[i].c[axis] <= bound : src[i].c[axis] >= bound;
            pi = upper ? prv.c[axis] <= bound : prv.c[axis] >= bound;
            if (ci != pi && w < MAXV)
            begin
                dst[w] = cross_pt(prv, src[i], axis, bound);
                w++;
            end
            if (ci && w < MAXV)
            begin
                dst[w] = src[i];
                w++;
            end
        end
        return w;
    endfunction

    function automatic logic [30:0] overlap_of(logic [IN_W-1:0] d);
        poly_t a;
        poly_t b;
        longint half;
        longint ox;
        longint oy;
        longint twice;
        int n;
        int j;
        logic [63:0] m;
        logic [63:0] res;
        half = longint'(1) << (FRAC_BITS - 1);
        ox = longint'(d[271:256]) << FRAC_BITS;
        oy = longint'(d[287:272]) << FRAC_BITS;
        for (int i = 0; i < 4; i++)
        begin
            a[i].c[0] = longint'($signed(d[64*i +: 32])) - ox;
            a[i].c[1] = longint'($signed(d[64*i+32 +: 32])) - oy;
        end
        n = clip_edge(a, 4, b, 0, 1'b0, -half);
        if (n < 3) return '0;
        n = clip_edge(b, n, a, 0, 1'b1, half);
        if (n < 3) return '0;
        n = clip_edge(a, n, b, 1, 1'b0, -half);
        if (n < 3) return '0;
        n = clip_edge(b, n, a, 1, 1'b1, half);
        if (n < 3) return '0;
        twice = 0;
        for (int i = 0; i < n; i++)
        begin
            j = i + 1 == n ? 0 : i + 1;
            twice += (a[i].c[0] + half) * (a[j].c[1] + half)
                   - (a[j].c[0] + half) * (a[i].c[1] + half);
        end
        m = mag(twice);
        // 2*FRAC_BITS+1-30 = 3 at FRAC_BITS 16, round half up
        res = (m + 64'd4) >> 3;
        if (res > 64'h4000_0000)
            res = 64'h4000_0000;
        return res[30:0];
    endfunction

    task automatic report_mismatch(string what, logic [30:0] got, logic [30:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    function automatic logic [IN_W-1:0] pack_quad(int x[4], int y[4], int px, int py);
        logic [IN_W-1:0] d;
        for (int i = 0; i < 4; i++)
        begin
            d[64*i +: 32] = x[i];
            d[64*i+32 +: 32] = y[i];
        end
        d[271:256] = px[15:0];
        d[287:272] = py[15:0];
        return d;
    endfunction

    // random quad near the pixel: offsets in Q16.16 within a few pixels
    function automatic logic [IN_W-1:0] near_quad(int span);
        int x[4];
        int y[4];
        int px;
        int py;
        int cx;
        int cy;
        px = $urandom_range(0, 65535);
        py = $urandom_range(0, 65535);
        cx = (px << 16) + $signed($urandom_range(0, 2 * span)) - span;
        cy = (py << 16) + $signed($urandom_range(0, 2 * span)) - span;
        for (int i = 0; i < 4; i++)
        begin
            x[i] = cx + $signed($urandom_range(0, 2 * span)) - span;
            y[i] = cy + $signed($urandom_range(0, 2 * span)) - span;
        end
        // axis-ish convex quad half the time
        if ($urandom_range(0, 1))
        begin
            x[1] = x[0] + $urandom_range(0, span);
            y[1] = y[0];
            x[2] = x[1];
            y[2] = y[0] + $urandom_range(0, span);
            x[3] = x[0];
            y[3] = y[2];
        end
        return pack_quad(x, y, px, py);
    endfunction

    initial
    begin
        int x[4];
        int y[4];
        logic [IN_W-1:0] d;
        rst_n = 1'b0;
        err_cnt = 0;
        gen_done = 1'b0;
        calm = 1'b0;
        // exact unit square on pixel (10,20): full area
        x = '{(10 << 16) - 32768, (10 << 16) + 32768, (10 << 16) + 32768, (10 << 16) - 32768};
        y = '{(20 << 16) - 32768, (20 << 16) - 32768, (20 << 16) + 32768, (20 << 16) + 32768};
        pending_q.push_back(pack_quad(x, y, 10, 20));
        // same square, reversed winding
        x = '{x[3], x[2], x[1], x[0]};
        y = '{y[3], y[2], y[1], y[0]};
        pending_q.push_back(pack_quad(x, y, 10, 20));
        // big quad covering pixel: saturates at 1.0
        x = '{-(1 << 30), (1 << 30), (1 << 30), -(1 << 30)};
        y = '{-(1 << 30), -(1 << 30), (1 << 30), (1 << 30)};
        pending_q.push_back(pack_quad(x, y, 0, 0));
        // field extremes
        x = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
        y = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
        pending_q.push_back(pack_quad(x, y, 0, 0));
        pending_q.push_back(pack_quad(x, y, 65535, 65535));
        pending_q.push_back(pack_quad(x, y, 32767, 32768));
        // degenerate: all vertices at one point, and far away
        x = '{65536, 65536, 65536, 65536};
        y = x;
        pending_q.push_back(pack_quad(x, y, 1, 1));
        pending_q.push_back(pack_quad(x, y, 500, 3));
        // self-intersecting bow tie over the pixel
        x = '{-40000, 40000, -40000, 40000};
        y = '{-40000, 40000, 40000, -40000};
        pending_q.push_back(pack_quad(x, y, 0, 0));
        // non-convex dart
        x = '{-50000, 0, 50000, 0};
        y = '{-50000, 50000, -50000, -10000};
        pending_q.push_back(pack_quad(x, y, 0, 0));
        // diamond larger than square: many crossings, clips to an octagon
        x = '{0, 45000, 0, -45000};
        y = '{-45000, 0, 45000, 0};
        pending_q.push_back(pack_quad(x, y, 0, 0));
        // thin sliver along an edge, and one touching a corner
        x = '{-32768, -32767, -32767, -32768};
        y = '{-32768, -32768, 32768, 32768};
        pending_q.push_back(pack_quad(x, y, 0, 0));
        x = '{32768, 90000, 90000, 32768};
        y = '{32768, 32768, 90000, 90000};
        pending_q.push_back(pack_quad(x, y, 0, 0));
        for (int i = 0; i < 1700; i++)
        begin
            if (i % 10 == 0)
            begin
                for (int k = 0; k < IN_W / 32; k++)
                    d[32*k +: 32] = $urandom;
                pending_q.push_back(d);
            end
            else
                pending_q.push_back(near_quad(i % 3 == 0 ? 200000 : 60000));
        end
        gen_done = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            idle_s        <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                area_q.push_back(overlap_of(s_axis_tdata));
                void'(pending_q.pop_front());
            end
            // last part of the run: no idling on either side
            if (pending_q.size() < 200)
                calm <= 1'b1;
            if (idle_s > 0)
            begin
                idle_s <= idle_s - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_q.size() > 0
                     && !(pending_q.size() < 200 ? 1'b0 : ($urandom_range(0, 9) == 0)))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_q[0];
                if (!calm && $urandom_range(0, 5) == 0)
                    idle_s <= $urandom_range(1, 7);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // response monitor and sink stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            idle_m        <= 0;
            wdog          <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (area_q.size() == 0)
                    report_mismatch("unexpected", m_axis_tdata[30:0], '0);
                else
                begin
                    if (m_axis_tdata[30:0] !== area_q[0])
                        report_mismatch("overlap_area", m_axis_tdata[30:0], area_q[0]);
                    void'(area_q.pop_front());
                end
                if (m_axis_tdata[31] !== 1'b0)
                    report_mismatch("pad bit", 31'(m_axis_tdata[31]), '0);
            end
            if (idle_m > 0)
            begin
                idle_m <= idle_m - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    idle_m <= $urandom_range(1, 7);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
        end
    end

    initial
    begin
        wait (gen_done && rst_n);
        fork
            begin
                wait (pending_q.size() == 0 && area_q.size() == 0 && !s_axis_tvalid);
                repeat (200) @(posedge clk);
            end
            wait (wdog >= WDOG_LIM);
        join_any
        if (wdog >= WDOG_LIM || area_q.size() != 0)
            $display("FAIL");
        else if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/qpoa_pkg.sv
rtl/qpoa_muldiv.sv
rtl/qpoa_datapath.sv
rtl/qpoa_ctrl.sv
rtl/quad_pixel_overlap_area.sv
tb/sv/quad_pixel_overlap_area_tb.sv
